/* src/swsl_pkg.sv */
// ----------------------------------------------------------------------------
// swsl_pkg: shared types and constants for the send limiter
// Sizes of the stamp rings, register map, refusal codes, config bundle.
// ----------------------------------------------------------------------------
package swsl_pkg;

	localparam int RING_DEPTH = 128;
	localparam int TIME_BITS  = 32;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int FILL_W     = $clog2(RING_DEPTH + 1);
	localparam int MEM_AW     = PTR_W + 1;
	localparam int NOW_W      = 32;
	localparam int GAP_W      = 16;
	localparam int CNT_W      = 8;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	// register index, taken from paddr[4:2]
	localparam logic [2:0] REG_MIN_GAP_NORMAL = 3'd0;
	localparam logic [2:0] REG_MIN_GAP_HIGH   = 3'd1;
	localparam logic [2:0] REG_MAX_CNT_NORMAL = 3'd2;
	localparam logic [2:0] REG_MAX_CNT_HIGH   = 3'd3;
	localparam logic [2:0] REG_WINDOW         = 3'd4;
	localparam logic [2:0] REG_HOLDOFF        = 3'd5;

	localparam logic [1:0] REF_NONE = 2'd0;
	localparam logic [1:0] REF_FAST = 2'd1;
	localparam logic [1:0] REF_MANY = 2'd2;

	typedef struct packed {
		logic [GAP_W-1:0] min_gap_normal;
		logic [GAP_W-1:0] min_gap_high;
		logic [CNT_W-1:0] max_cnt_normal;
		logic [CNT_W-1:0] max_cnt_high;
		logic [GAP_W-1:0] window;
		logic [GAP_W-1:0] holdoff;
	} cfg_t;

endpackage

/* src/swsl_core.sv */
// ----------------------------------------------------------------------------
// swsl_core: stamp rings and decision sequencer
// One memory holds both class rings; a small FSM walks the newest-stamp
// check and the window purge through one subtract unit, then the count check.
// ----------------------------------------------------------------------------
module swsl_core
	import swsl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [NOW_W-1:0] now_ms,
	input  logic             high_rate,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             accepted,
	output logic [1:0]       refusal,
	output logic             notify
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_GAP   = 2'd1;
	localparam logic [1:0] ST_PURGE = 2'd2;
	localparam logic [1:0] ST_CNT   = 2'd3;

	logic [1:0]           state_q;
	logic [TIME_BITS-1:0] now_q;
	logic                 cls_q;
	logic [PTR_W-1:0]     head_q [2];
	logic [FILL_W-1:0]    fill_q [2];
	logic [TIME_BITS-1:0] spd_time_q;
	logic                 spd_seen_q;
	logic [TIME_BITS-1:0] cnt_time_q;
	logic                 cnt_seen_q;
	logic [TIME_BITS-1:0] rd_data_q;
	logic                 out_valid_q;
	logic                 accepted_q;
	logic [1:0]           refusal_q;
	logic                 notify_q;

	logic [TIME_BITS-1:0] stamp_mem [2**MEM_AW];

	logic [PTR_W-1:0]     head_in, head_c;
	logic [FILL_W-1:0]    fill_in, fill_c, lim_c;
	logic [CNT_W-1:0]     lim_raw;
	logic [GAP_W-1:0]     gap_c;
	logic [TIME_BITS-1:0] diff_rd;
	logic                 in_take, out_free, out_load;
	logic                 too_fast, too_old, full, spd_ok, cnt_ok;
	logic [MEM_AW-1:0]    rd_addr, wr_addr;
	logic                 wr_en;

	// ring index add with wrap; off exceeds the depth only in the idle read of an empty ring, whose data goes unused
	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] base,
			input logic [FILL_W-1:0] off);
		logic [PTR_W:0] sum;
		sum = (PTR_W+1)'(base) + (PTR_W+1)'(off);
		if (sum >= (PTR_W+1)'(RING_DEPTH)) begin
			sum = sum - (PTR_W+1)'(RING_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	assign head_in  = head_q[high_rate];
	assign fill_in  = fill_q[high_rate];
	assign head_c   = head_q[cls_q];
	assign fill_c   = fill_q[cls_q];
	assign gap_c    = cls_q ? cfg.min_gap_high : cfg.min_gap_normal;
	assign lim_raw  = cls_q ? cfg.max_cnt_high : cfg.max_cnt_normal;
	assign lim_c    = (int'(lim_raw) > RING_DEPTH) ? FILL_W'(RING_DEPTH) : FILL_W'(lim_raw);

	assign in_take  = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// the shared subtract: now minus the stamp just read
	assign diff_rd  = now_q - rd_data_q;
	assign too_fast = diff_rd < TIME_BITS'(gap_c);
	assign too_old  = diff_rd > TIME_BITS'(cfg.window);
	assign full     = fill_c >= lim_c;
	assign spd_ok   = !spd_seen_q || ((now_q - spd_time_q) > TIME_BITS'(cfg.holdoff));
	assign cnt_ok   = !cnt_seen_q || ((now_q - cnt_time_q) > TIME_BITS'(cfg.holdoff));

	assign out_load = out_free && (((state_q == ST_GAP) && too_fast) || (state_q == ST_CNT));

	always_comb begin
		if (state_q == ST_IDLE) begin
			rd_addr = {high_rate, ptr_add(head_in, fill_in - FILL_W'(1))};
		end else if (state_q == ST_GAP && too_fast) begin
			// keep the newest stamp while a too-fast verdict waits
			rd_addr = {cls_q, ptr_add(head_c, fill_c - FILL_W'(1))};
		end else if (state_q == ST_PURGE && too_old) begin
			rd_addr = {cls_q, ptr_add(head_c, FILL_W'(1))};
		end else begin
			rd_addr = {cls_q, head_c};
		end
	end

	assign wr_en   = (state_q == ST_CNT) && out_free && !full;
	assign wr_addr = {cls_q, ptr_add(head_c, fill_c)};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stamp_mem[wr_addr] <= now_q;
		end
		rd_data_q <= stamp_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			now_q <= TIME_BITS'(now_ms);
			cls_q <= high_rate;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q[0]   <= '0;
			head_q[1]   <= '0;
			fill_q[0]   <= '0;
			fill_q[1]   <= '0;
			spd_time_q  <= '0;
			spd_seen_q  <= 1'b0;
			cnt_time_q  <= '0;
			cnt_seen_q  <= 1'b0;
			out_valid_q <= 1'b0;
			accepted_q  <= 1'b0;
			refusal_q   <= REF_NONE;
			notify_q    <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= (fill_in != '0) ? ST_GAP : ST_CNT;
					end
				end
				ST_GAP: begin
					if (!too_fast) begin
						state_q <= ST_PURGE;
					end else if (out_free) begin
						accepted_q  <= 1'b0;
						refusal_q   <= REF_FAST;
						notify_q    <= spd_ok;
						if (spd_ok) begin
							spd_time_q <= now_q;
							spd_seen_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_PURGE: begin
					if (too_old) begin
						head_q[cls_q] <= ptr_add(head_c, FILL_W'(1));
						fill_q[cls_q] <= fill_c - FILL_W'(1);
						if (fill_c == FILL_W'(1)) begin
							state_q <= ST_CNT;
						end
					end else begin
						state_q <= ST_CNT;
					end
				end
				ST_CNT: begin
					if (out_free) begin
						if (full) begin
							accepted_q <= 1'b0;
							refusal_q  <= REF_MANY;
							notify_q   <= cnt_ok;
							if (cnt_ok) begin
								cnt_time_q <= now_q;
								cnt_seen_q <= 1'b1;
							end
						end else begin
							accepted_q    <= 1'b1;
							refusal_q     <= REF_NONE;
							notify_q      <= 1'b0;
							fill_q[cls_q] <= fill_c + FILL_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign refusal   = refusal_q;
	assign notify    = notify_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q[0] <= FILL_W'(RING_DEPTH)) && (fill_q[1] <= FILL_W'(RING_DEPTH)))
		else $error("ring fill beyond depth");

	a_purge_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PURGE) |-> (fill_c != '0))
		else $error("purge on empty ring");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (fill_c == $past(fill_c) + FILL_W'(1)))
		else $error("accepted word did not grow the ring");

	a_accept_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && accepted_q) |-> (refusal_q == REF_NONE && !notify_q))
		else $error("accepted word carries a refusal");

endmodule

/* src/sliding_window_send_limiter.sv */
// ----------------------------------------------------------------------------
// sliding_window_send_limiter: per-class sliding-window send rate limiter
// Input words carry a ms time and a class bit; each returns one verdict
// word (accepted, refusal code, notify). Config via an APB-style port.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid/in_stall with now_ms and high_rate. in_stall is
//   high while a word is being worked on; one word is handled at a time.
//   Output channel: out_valid/out_stall with accepted, refusal, notify; one
//   result word per input word, held in an output register.
//   Timing: a too-fast refusal is posted straight from the newest-stamp
//   check, and a word for an empty class ring goes straight to the count
//   check; otherwise the window purge drops old stamps before the count
//   check. The purge loop and the single stamp memory port set the pace:
//   one stamp is read and compared per cycle.
//   Flow: the next word is taken at the edge after its predecessor's
//   verdict is posted; each stamp is dropped once, so the purge drops at
//   most one stamp per accepted word on average.
//   Stall: while out_stall holds a result, the next word is still taken and
//   worked on up to its verdict, which waits for the output register.
//   Reset (arst_n low): rings empty, notices never seen, config registers
//   at their defaults. Config writes belong to idle periods only.
// ----------------------------------------------------------------------------
module sliding_window_send_limiter
	import swsl_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [NOW_W-1:0]  now_ms,
	input  logic              high_rate,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              accepted,
	output logic [1:0]        refusal,
	output logic              notify
);

	cfg_t       cfg_q;
	logic       wr_hit;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_hit  = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_gap_normal <= GAP_W'(1100);
			cfg_q.min_gap_high   <= GAP_W'(100);
			cfg_q.max_cnt_normal <= CNT_W'(19);
			cfg_q.max_cnt_high   <= CNT_W'(99);
			cfg_q.window         <= GAP_W'(32000);
			cfg_q.holdoff        <= GAP_W'(30000);
		end else if (wr_hit) begin
			case (reg_idx)
				REG_MIN_GAP_NORMAL: cfg_q.min_gap_normal <= pwdata[GAP_W-1:0];
				REG_MIN_GAP_HIGH:   cfg_q.min_gap_high   <= pwdata[GAP_W-1:0];
				REG_MAX_CNT_NORMAL: cfg_q.max_cnt_normal <= pwdata[CNT_W-1:0];
				REG_MAX_CNT_HIGH:   cfg_q.max_cnt_high   <= pwdata[CNT_W-1:0];
				REG_WINDOW:         cfg_q.window         <= pwdata[GAP_W-1:0];
				REG_HOLDOFF:        cfg_q.holdoff        <= pwdata[GAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_MIN_GAP_NORMAL: prdata = DATA_W'(cfg_q.min_gap_normal);
			REG_MIN_GAP_HIGH:   prdata = DATA_W'(cfg_q.min_gap_high);
			REG_MAX_CNT_NORMAL: prdata = DATA_W'(cfg_q.max_cnt_normal);
			REG_MAX_CNT_HIGH:   prdata = DATA_W'(cfg_q.max_cnt_high);
			REG_WINDOW:         prdata = DATA_W'(cfg_q.window);
			REG_HOLDOFF:        prdata = DATA_W'(cfg_q.holdoff);
			default:            prdata = '0;
		endcase
	end

	swsl_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.now_ms    (now_ms),
		.high_rate (high_rate),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.accepted  (accepted),
		.refusal   (refusal),
		.notify    (notify)
	);

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for sliding_window_send_limiter
// Requests go in through a valid/stall driver fed from a queue. A predictor
// keeps its own stamp rings and notice state and works out each verdict as
// a word is taken. A monitor compares each verdict word with the oldest
// expected one. Directed cases come first, then random traffic under
// several register settings written over the APB-style port.
// ----------------------------------------------------------------------------
module testbench;
	import swsl_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int SPEED_NOTICE = 0;
	localparam int COUNT_NOTICE = 1;

	typedef struct packed {
		logic [NOW_W-1:0] now;
		logic             hi;
		logic             drain;	// sender waits for all verdicts before this word
	} request_t;

	typedef struct packed {
		logic       acc;
		logic [1:0] refusal;
		logic       notify;
	} verdict_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid  = 1'b0;
	logic              in_stall;
	logic [NOW_W-1:0]  now_ms    = '0;
	logic              high_rate = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic              accepted;
	logic [1:0]        refusal;
	logic              notify;

	sliding_window_send_limiter u_top (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	cfg_t                 cfg;
	logic [TIME_BITS-1:0] stamps [2][RING_DEPTH];
	int                   head [2] = '{default: 0};
	int                   fill [2] = '{default: 0};
	logic [TIME_BITS-1:0] notice_at [2] = '{default: '0};
	bit                   notice_seen [2] = '{default: 1'b0};

	request_t       send_queue [$];
	verdict_t       verdict_q [$];
	bit             word_taken = 1'b0;
	int             in_count   = 0;
	int             errors     = 0;
	int             cycles     = 0;
	int             hold_left  = 0;
	bit             hold_done  = 1'b0;
	logic [NOW_W-1:0] t_ms;

	// a quiet stretch with no idling on either side
	wire calm = (in_count >= 900) && (in_count < 1150);

	function automatic logic [TIME_BITS-1:0] age(input logic [TIME_BITS-1:0] a,
			input logic [TIME_BITS-1:0] b);
		return a - b;
	endfunction

	function automatic logic notice_due(input int kind, input logic [TIME_BITS-1:0] now);
		if (!notice_seen[kind] || age(now, notice_at[kind]) > TIME_BITS'(cfg.holdoff)) begin
			notice_at[kind] = now;
			notice_seen[kind] = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic verdict_t judge_request(input logic [NOW_W-1:0] now, input logic hi);
		verdict_t             v;
		int                   cls;
		int                   limit;
		logic [TIME_BITS-1:0] gap;
		cls = int'(hi);
		v = '{acc: 1'b0, refusal: REF_NONE, notify: 1'b0};
		gap = TIME_BITS'(hi ? cfg.min_gap_high : cfg.min_gap_normal);
		limit = int'(hi ? cfg.max_cnt_high : cfg.max_cnt_normal);
		if (limit > RING_DEPTH)
			limit = RING_DEPTH;
		if (fill[cls] != 0 &&
				age(now, stamps[cls][(head[cls] + fill[cls] - 1) % RING_DEPTH]) < gap) begin
			v.refusal = REF_FAST;
			v.notify = notice_due(SPEED_NOTICE, now);
		end else begin
			while (fill[cls] != 0 &&
					age(now, stamps[cls][head[cls]]) > TIME_BITS'(cfg.window)) begin
				head[cls] = (head[cls] + 1) % RING_DEPTH;
				fill[cls]--;
			end
			if (fill[cls] >= limit) begin
				v.refusal = REF_MANY;
				v.notify = notice_due(COUNT_NOTICE, now);
			end else begin
				stamps[cls][(head[cls] + fill[cls]) % RING_DEPTH] = now;
				fill[cls]++;
				v.acc = 1'b1;
			end
		end
		return v;
	endfunction

	task automatic check_field(input string name, input logic [1:0] got, input logic [1:0] want);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	// sender: new word only once the previous one was taken
	always @(negedge clk) begin : drive
		request_t nxt;
		if (!in_valid || word_taken) begin
			if (send_queue.size() != 0 && (calm || $urandom_range(99) >= 20) &&
					!(send_queue[0].drain && verdict_q.size() != 0)) begin
				nxt = send_queue.pop_front();
				in_valid <= 1'b1;
				now_ms <= nxt.now;
				high_rate <= nxt.hi;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, plus one long hold so the block backs up
	always @(negedge clk) begin
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && in_count >= 300) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !calm && ($urandom_range(99) < 20);
		end
	end

	always @(posedge clk) begin : watch
		verdict_t want;
		word_taken <= in_valid && !in_stall;
		if (arst_n) begin
			// pop before push: a verdict never belongs to the word taken this edge
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$display("%0t: verdict word with nothing expected, got %0d/%0d/%0d",
						$time, accepted, refusal, notify);
					errors++;
				end else begin
					want = verdict_q.pop_front();
					check_field("accepted", 2'(accepted), 2'(want.acc));
					check_field("refusal", refusal, want.refusal);
					check_field("notify", 2'(notify), 2'(want.notify));
				end
			end
			if (in_valid && !in_stall) begin
				verdict_q.push_back(judge_request(now_ms, high_rate));
				in_count <= in_count + 1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_MIN_GAP_NORMAL: cfg.min_gap_normal = value[GAP_W-1:0];
			REG_MIN_GAP_HIGH:   cfg.min_gap_high = value[GAP_W-1:0];
			REG_MAX_CNT_NORMAL: cfg.max_cnt_normal = value[CNT_W-1:0];
			REG_MAX_CNT_HIGH:   cfg.max_cnt_high = value[CNT_W-1:0];
			REG_WINDOW:         cfg.window = value[GAP_W-1:0];
			REG_HOLDOFF:        cfg.holdoff = value[GAP_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// all six registers; upper data bits carry junk that must be dropped
	task automatic load_config(input logic [15:0] gap_n, input logic [15:0] gap_h,
			input logic [7:0] cnt_n, input logic [7:0] cnt_h,
			input logic [15:0] window, input logic [15:0] holdoff);
		logic [31:0] junk;
		junk = $urandom();
		write_reg(REG_MIN_GAP_NORMAL, {junk[31:16], gap_n});
		write_reg(REG_MIN_GAP_HIGH, {junk[31:16], gap_h});
		write_reg(REG_MAX_CNT_NORMAL, {junk[31:8], cnt_n});
		write_reg(REG_MAX_CNT_HIGH, {junk[31:8], cnt_h});
		write_reg(REG_WINDOW, {junk[31:16], window});
		write_reg(REG_HOLDOFF, {junk[31:16], holdoff});
	endtask

	task automatic add_request(input logic [NOW_W-1:0] now, input logic hi);
		send_queue.push_back('{now: now, hi: hi, drain: 1'b0});
	endtask

	// mostly a steady clock paced near the class gap, with repeats,
	// backward stamps, jumps and fully random times mixed in
	task automatic add_traffic(input int n, input int jump_pct);
		request_t r;
		int       pick;
		int       gap;
		for (int i = 0; i < n; i++) begin
			r.hi = 1'($urandom_range(1));
			r.drain = ($urandom_range(99) == 0);
			gap = int'(r.hi ? cfg.min_gap_high : cfg.min_gap_normal);
			pick = $urandom_range(99);
			if (pick < 5) begin
				r.now = $urandom();
			end else if (pick < 11) begin
				r.now = t_ms - $urandom_range(3000);
			end else begin
				if (pick < 11 + jump_pct)
					t_ms = t_ms + $urandom_range(70000);
				else if (pick >= 18 + jump_pct)
					t_ms = t_ms + $urandom_range(2 * gap + 64);
				r.now = t_ms;
			end
			send_queue.push_back(r);
		end
	endtask

	task automatic settle();
		do @(posedge clk); while (send_queue.size() != 0 || in_valid || verdict_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		cfg = '{min_gap_normal: 16'd1100, min_gap_high: 16'd100, max_cnt_normal: 8'd19,
			max_cnt_high: 8'd99, window: 16'd32000, holdoff: 16'd30000};
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// defaults: gap boundary, first notice, stamp ahead of now, wrap
		add_request(32'd0, 1'b0);
		add_request(32'd0, 1'b0);
		add_request(32'd500, 1'b0);
		add_request(32'd1100, 1'b0);
		add_request(32'hFFFF_FFFF, 1'b0);
		add_request(32'hFFFF_FFFF, 1'b1);
		add_request(32'd50, 1'b1);
		add_request(32'd30050, 1'b1);
		add_request(32'd30060, 1'b1);
		settle();

		// zero limit, tiny ring, window edge
		write_reg(REG_MAX_CNT_NORMAL, 32'd0);
		write_reg(REG_MAX_CNT_HIGH, 32'd2);
		write_reg(REG_WINDOW, 32'd1000);
		write_reg(REG_MIN_GAP_HIGH, 32'd0);
		add_request(32'd100000, 1'b0);
		add_request(32'd100000, 1'b1);
		add_request(32'd100000, 1'b1);
		add_request(32'd101000, 1'b1);
		add_request(32'd101001, 1'b1);
		add_request(32'd101001, 1'b0);
		add_request(32'd140000, 1'b0);
		settle();

		load_config(16'd1100, 16'd100, 8'd19, 8'd99, 16'd32000, 16'd30000);
		t_ms = 32'hFFFF_0000;
		add_traffic(450, 8);
		settle();

		// rings fill to depth; limit above depth must clamp
		load_config(16'd0, 16'd0, 8'd255, 8'd128, 16'hFFFF, 16'd0);
		t_ms = $urandom();
		add_traffic(300, 0);
		add_traffic(60, 15);
		settle();

		load_config(16'hFFFF, 16'hFFFF, 8'd128, 8'd1, 16'd0, 16'hFFFF);
		t_ms = 32'h7FFF_F000;
		add_traffic(150, 8);
		settle();

		repeat (3) begin
			load_config(16'($urandom_range(2000)), 16'($urandom_range(2000)),
				8'($urandom_range(128)), 8'($urandom_range(128)),
				16'($urandom_range(65535)), 16'($urandom_range(65535)));
			t_ms = $urandom();
			add_traffic(150, 8);
			settle();
		end

		load_config(16'd1100, 16'd100, 8'd19, 8'd99, 16'd32000, 16'd30000);
		add_traffic(200, 8);
		settle();

		repeat (150) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
